### hdl/pct_pkg.sv
`default_nettype none

package pct_pkg;

   localparam int BLOCK_ENTRIES  = 64;
   localparam int BRANCH_ENTRIES = 64;
   localparam int COUNT_BITS     = 32;

   localparam int BLK_IDX_BITS = $clog2(BLOCK_ENTRIES);
   localparam int BRN_IDX_BITS = $clog2(BRANCH_ENTRIES);

   localparam int KEY_BITS    = 24;
   localparam int REPORT_BITS = 32;
   localparam int ENTRY_BITS  = 6;
   localparam int STATUS_BITS = 3;
   localparam int REQ_BITS    = 2;

   // request codes
   localparam logic [REQ_BITS-1:0] REQ_BLOCK  = 2'd0;
   localparam logic [REQ_BITS-1:0] REQ_BRANCH = 2'd1;
   localparam logic [REQ_BITS-1:0] REQ_CLEAR  = 2'd2;

   // result status codes
   localparam logic [STATUS_BITS-1:0] STAT_UPDATED  = 3'd0;
   localparam logic [STATUS_BITS-1:0] STAT_INSERTED = 3'd1;
   localparam logic [STATUS_BITS-1:0] STAT_FULL     = 3'd2;
   localparam logic [STATUS_BITS-1:0] STAT_IGNORED  = 3'd3;
   localparam logic [STATUS_BITS-1:0] STAT_CLEARED  = 3'd4;

   typedef logic [COUNT_BITS-1:0] count_type;

   function automatic count_type sat_inc(input count_type v);
      return (v == '1) ? v : v + COUNT_BITS'(1);
   endfunction

   // counters wider than the report field clamp at the field's top value
   function automatic logic [REPORT_BITS-1:0] show_count(input count_type v);
      logic [63:0] wide;
      wide = 64'(v);
      if (wide > 64'h0000_0000_FFFF_FFFF) begin
         return '1;
      end
      return wide[REPORT_BITS-1:0];
   endfunction

   function automatic logic [ENTRY_BITS-1:0] slot_field(input logic [15:0] slot);
      return slot[ENTRY_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

### hdl/profile_counter_table.sv
// An accepted request is registered, handled in the write-back state, and its result is then
// registered onto the rsp_ ports, strobed by rsp_valid for one cycle.
// A new request is not taken until the last one is through: key match and count read, then write-back.
// The receiver cannot stall; busy is high only during the write-back cycle.
// Reset (synchronous, active high) empties both tables at once and sets profiling on.
`default_nettype none

module profile_counter_table (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [pct_pkg::REQ_BITS-1:0]      req_type,
   input  wire logic [7:0]                        req_func_id,
   input  wire logic [15:0]                       req_item_id,
   input  wire logic                              req_taken,
   output logic                                   rsp_valid,
   output logic [pct_pkg::STATUS_BITS-1:0]        rsp_status,
   output logic [pct_pkg::REPORT_BITS-1:0]        rsp_first_count,
   output logic [pct_pkg::REPORT_BITS-1:0]        rsp_second_count,
   output logic [pct_pkg::ENTRY_BITS-1:0]         rsp_entry_index,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic                              csr_wdata
);

   localparam int BLK_N  = pct_pkg::BLOCK_ENTRIES;
   localparam int BRN_N  = pct_pkg::BRANCH_ENTRIES;
   localparam int BLK_IW = pct_pkg::BLK_IDX_BITS;
   localparam int BRN_IW = pct_pkg::BRN_IDX_BITS;
   localparam int CB     = pct_pkg::COUNT_BITS;

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } state_type;

   typedef enum logic [1:0] {
      ACT_IGNORE,
      ACT_CLEAR,
      ACT_BLOCK,
      ACT_BRANCH
   } act_type;

   state_type state_ff;
   act_type   act_ff, act_in;

   logic enable_ff;

   // key store and valid bits: flip-flops, matched in parallel
   logic [pct_pkg::KEY_BITS-1:0] blk_key_ff [BLK_N];
   logic [pct_pkg::KEY_BITS-1:0] brn_key_ff [BRN_N];
   logic [BLK_N-1:0]             blk_valid_ff;
   logic [BRN_N-1:0]             brn_valid_ff;
   logic [BLK_IW:0]              blk_fill_ff;
   logic [BRN_IW:0]              brn_fill_ff;

   // count memories; the branch word holds {taken, not taken}
   pct_pkg::count_type blk_mem [BLK_N];
   logic [2*CB-1:0]    brn_mem [BRN_N];
   pct_pkg::count_type blk_rd_ff;
   logic [2*CB-1:0]    brn_rd_ff;

   logic [pct_pkg::KEY_BITS-1:0] key_in, key_ff;
   logic                         taken_ff;
   logic [BLK_N-1:0]             blk_match;
   logic [BRN_N-1:0]             brn_match;
   logic [BLK_IW-1:0]            blk_hit_idx, blk_idx_ff;
   logic [BRN_IW-1:0]            brn_hit_idx, brn_idx_ff;
   logic                         blk_hit_ff, brn_hit_ff;
   logic                         accept;

   // write-back cycle results
   logic [pct_pkg::STATUS_BITS-1:0] status_in;
   logic [pct_pkg::REPORT_BITS-1:0] first_in, second_in;
   logic [15:0]                     slot_in;
   logic                            blk_wr, brn_wr, blk_ins, brn_ins;
   logic [BLK_IW-1:0]               blk_wr_idx;
   logic [BRN_IW-1:0]               brn_wr_idx;
   pct_pkg::count_type              blk_wr_data;
   pct_pkg::count_type              tk_cnt, nt_cnt;

   logic                            rsp_valid_ff;
   logic [pct_pkg::STATUS_BITS-1:0] rsp_status_ff;
   logic [pct_pkg::REPORT_BITS-1:0] rsp_first_ff, rsp_second_ff;
   logic [pct_pkg::ENTRY_BITS-1:0]  rsp_entry_ff;

   assign busy      = (state_ff == ST_UPDATE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign key_in    = {req_func_id, req_item_id};

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_first_count  = rsp_first_ff;
   assign rsp_second_count = rsp_second_ff;
   assign rsp_entry_index  = rsp_entry_ff;

   // keys are unique in a table, so at most one match: OR the indices together
   always_comb begin
      blk_hit_idx = '0;
      for (int i = 0; i < BLK_N; i++) begin
         blk_match[i] = blk_valid_ff[i] && (blk_key_ff[i] == key_in);
         if (blk_match[i]) begin
            blk_hit_idx = blk_hit_idx | BLK_IW'(i);
         end
      end
      brn_hit_idx = '0;
      for (int i = 0; i < BRN_N; i++) begin
         brn_match[i] = brn_valid_ff[i] && (brn_key_ff[i] == key_in);
         if (brn_match[i]) begin
            brn_hit_idx = brn_hit_idx | BRN_IW'(i);
         end
      end
   end

   always_comb begin
      act_in = ACT_IGNORE;
      if (req_type == pct_pkg::REQ_CLEAR) begin
         act_in = ACT_CLEAR;
      end else if (req_type == pct_pkg::REQ_BLOCK && enable_ff) begin
         act_in = ACT_BLOCK;
      end else if (req_type == pct_pkg::REQ_BRANCH && enable_ff) begin
         act_in = ACT_BRANCH;
      end
   end

   always_comb begin
      status_in   = pct_pkg::STAT_IGNORED;
      first_in    = '0;
      second_in   = '0;
      slot_in     = '0;
      blk_wr      = 1'b0;
      brn_wr      = 1'b0;
      blk_ins     = 1'b0;
      brn_ins     = 1'b0;
      blk_wr_idx  = blk_idx_ff;
      brn_wr_idx  = brn_idx_ff;
      blk_wr_data = pct_pkg::sat_inc(blk_rd_ff);
      tk_cnt      = brn_rd_ff[2*CB-1:CB];
      nt_cnt      = brn_rd_ff[CB-1:0];
      case (act_ff)
         ACT_CLEAR: begin
            status_in = pct_pkg::STAT_CLEARED;
         end
         ACT_BLOCK: begin
            if (blk_hit_ff) begin
               blk_wr    = 1'b1;
               status_in = pct_pkg::STAT_UPDATED;
            end else if (blk_fill_ff < (BLK_IW+1)'(BLK_N)) begin
               blk_wr      = 1'b1;
               blk_ins     = 1'b1;
               blk_wr_idx  = blk_fill_ff[BLK_IW-1:0];
               blk_wr_data = CB'(1);
               status_in   = pct_pkg::STAT_INSERTED;
            end else begin
               status_in = pct_pkg::STAT_FULL;
            end
            if (blk_wr) begin
               first_in = pct_pkg::show_count(blk_wr_data);
               slot_in  = 16'(blk_wr_idx);
            end
         end
         ACT_BRANCH: begin
            if (brn_hit_ff) begin
               brn_wr    = 1'b1;
               status_in = pct_pkg::STAT_UPDATED;
               if (taken_ff) begin
                  tk_cnt = pct_pkg::sat_inc(tk_cnt);
               end else begin
                  nt_cnt = pct_pkg::sat_inc(nt_cnt);
               end
            end else if (brn_fill_ff < (BRN_IW+1)'(BRN_N)) begin
               brn_wr     = 1'b1;
               brn_ins    = 1'b1;
               brn_wr_idx = brn_fill_ff[BRN_IW-1:0];
               tk_cnt     = CB'(taken_ff);
               nt_cnt     = CB'(!taken_ff);
               status_in  = pct_pkg::STAT_INSERTED;
            end else begin
               status_in = pct_pkg::STAT_FULL;
            end
            if (brn_wr) begin
               first_in  = pct_pkg::show_count(tk_cnt);
               second_in = pct_pkg::show_count(nt_cnt);
               slot_in   = 16'(brn_wr_idx);
            end
         end
         default: begin
            status_in = pct_pkg::STAT_IGNORED;
         end
      endcase
   end

   // sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         act_ff       <= ACT_IGNORE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               rsp_valid_ff <= 1'b0;
               if (accept) begin
                  state_ff <= ST_UPDATE;
                  act_ff   <= act_in;
               end
            end
            ST_UPDATE: begin
               state_ff     <= ST_IDLE;
               rsp_valid_ff <= 1'b1;
            end
            default: begin
               state_ff     <= ST_IDLE;
               rsp_valid_ff <= 1'b0;
            end
         endcase
      end
      if (accept) begin
         key_ff     <= key_in;
         taken_ff   <= req_taken;
         blk_hit_ff <= |blk_match;
         brn_hit_ff <= |brn_match;
         blk_idx_ff <= blk_hit_idx;
         brn_idx_ff <= brn_hit_idx;
      end
      if (state_ff == ST_UPDATE) begin
         rsp_status_ff <= status_in;
         rsp_first_ff  <= first_in;
         rsp_second_ff <= second_in;
         rsp_entry_ff  <= pct_pkg::slot_field(slot_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         enable_ff <= csr_wdata;
      end
   end

   // valid bits and fill counts; a clear drops everything at once
   always_ff @(posedge clock) begin
      if (reset) begin
         blk_valid_ff <= '0;
         brn_valid_ff <= '0;
         blk_fill_ff  <= '0;
         brn_fill_ff  <= '0;
      end else if (state_ff == ST_UPDATE) begin
         if (act_ff == ACT_CLEAR) begin
            blk_valid_ff <= '0;
            brn_valid_ff <= '0;
            blk_fill_ff  <= '0;
            brn_fill_ff  <= '0;
         end
         if (blk_ins) begin
            blk_valid_ff[blk_wr_idx] <= 1'b1;
            blk_fill_ff              <= blk_fill_ff + (BLK_IW+1)'(1);
         end
         if (brn_ins) begin
            brn_valid_ff[brn_wr_idx] <= 1'b1;
            brn_fill_ff              <= brn_fill_ff + (BRN_IW+1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_UPDATE && blk_ins) begin
         blk_key_ff[blk_wr_idx] <= key_ff;
      end
      if (state_ff == ST_UPDATE && brn_ins) begin
         brn_key_ff[brn_wr_idx] <= key_ff;
      end
   end

   // count memories: read issued in the accept cycle, written back in the cycle after it;
   // busy keeps the next read off the entry being written
   always_ff @(posedge clock) begin
      blk_rd_ff <= blk_mem[blk_hit_idx];
      brn_rd_ff <= brn_mem[brn_hit_idx];
      if (state_ff == ST_UPDATE && blk_wr) begin
         blk_mem[blk_wr_idx] <= blk_wr_data;
      end
      if (state_ff == ST_UPDATE && brn_wr) begin
         brn_mem[brn_wr_idx] <= {tk_cnt, nt_cnt};
      end
   end

`ifndef SYNTHESIS
   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted beat did not enter write-back");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      busy |=> (rsp_valid && !busy))
      else $error("write-back did not produce exactly one result");

   a_blk_fill_bound: assert property (@(posedge clock) disable iff (reset)
      blk_fill_ff <= (BLK_IW+1)'(BLK_N))
      else $error("block fill count overran the table");

   a_brn_fill_bound: assert property (@(posedge clock) disable iff (reset)
      brn_fill_ff <= (BRN_IW+1)'(BRN_N))
      else $error("branch fill count overran the table");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (busy && blk_ins) |=> (blk_fill_ff == $past(blk_fill_ff) + (BLK_IW+1)'(1)))
      else $error("block insert did not advance the fill count");
`endif

endmodule

`default_nettype wire
